/* src/jse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared types, constants and character helpers of the escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

    localparam int MAX_OUT = 8;
    localparam int CNT_W   = 4;
    localparam int BODY_W  = 3;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [1:0] follow_left;
        logic       terminated;
        logic       seq_dropped;
    } t_state;

    typedef struct packed {
        logic  has_byte;
        t_byte byte_in;
        logic  string_start;
        logic  string_end;
    } t_item;

    function automatic t_byte short_code(input t_byte b);
        t_byte sc;
        begin
            unique case (b)
                8'h08:        sc = 8'h62;
                8'h09:        sc = 8'h74;
                8'h0A:        sc = 8'h6E;
                8'h0C:        sc = 8'h66;
                8'h0D:        sc = 8'h72;
                CH_QUOTE:     sc = CH_QUOTE;
                CH_BACKSLASH: sc = CH_BACKSLASH;
                default:      sc = 8'h00;
            endcase
            return sc;
        end
    endfunction

    function automatic t_byte hex_digit(input logic [3:0] v);
        begin
            if (v < 4'd10) begin
                return 8'h30 + {4'd0, v};
            end else begin
                return 8'h37 + {4'd0, v};
            end
        end
    endfunction

endpackage

/* src/jse_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper encoder
// Holds the UTF-8 sequence state and turns one item into its escaped bytes.
// ----------------------------------------------------------------------------
module jse_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  jse_pkg::t_item              i_item,
    output jse_pkg::t_byte              o_bytes [jse_pkg::MAX_OUT],
    output logic [jse_pkg::CNT_W-1:0]   o_count
);

    jse_pkg::t_state r_state;
    jse_pkg::t_state n_state;
    jse_pkg::t_byte  body [jse_pkg::MAX_OUT];
    logic [jse_pkg::BODY_W-1:0] body_n;
    jse_pkg::t_byte  b;
    jse_pkg::t_byte  sc;
    logic [jse_pkg::CNT_W-1:0] pos;

    assign b  = i_item.byte_in;
    assign sc = jse_pkg::short_code(b);

    always_comb begin
        n_state = r_state;
        body_n  = '0;
        for (int i = 0; i < jse_pkg::MAX_OUT; i++) begin
            body[i] = '0;
        end
        if (i_item.string_start) begin
            n_state = '0;
        end
        if (i_item.has_byte && !n_state.terminated) begin
            if (n_state.follow_left != 2'd0) begin
                if (b == 8'h00) begin
                    n_state.seq_dropped = 1'b1;
                end
                if (!n_state.seq_dropped) begin
                    body[0] = b;
                    body_n  = 3'd1;
                end
                n_state.follow_left = n_state.follow_left - 2'd1;
                if (n_state.follow_left == 2'd0) begin
                    n_state.seq_dropped = 1'b0;
                end
            end else if (b == 8'h00) begin
                n_state.terminated = 1'b1;
            end else if (!b[7]) begin
                if (sc != 8'h00) begin
                    body[0] = jse_pkg::CH_BACKSLASH;
                    body[1] = sc;
                    body_n  = 3'd2;
                end else if (b < jse_pkg::CH_SPACE || b == jse_pkg::CH_DEL) begin
                    body[0] = jse_pkg::CH_BACKSLASH;
                    body[1] = jse_pkg::CH_U;
                    body[2] = jse_pkg::CH_ZERO;
                    body[3] = jse_pkg::CH_ZERO;
                    body[4] = jse_pkg::hex_digit(b[7:4]);
                    body[5] = jse_pkg::hex_digit(b[3:0]);
                    body_n  = 3'd6;
                end else begin
                    body[0] = b;
                    body_n  = 3'd1;
                end
            end else if ((b & 8'hE0) == 8'hC0) begin
                body[0] = b;
                body_n  = 3'd1;
                n_state.follow_left = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
                body[0] = b;
                body_n  = 3'd1;
                n_state.follow_left = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
                body[0] = b;
                body_n  = 3'd1;
                n_state.follow_left = 2'd3;
            end
        end
        if (i_item.string_end) begin
            n_state = '0;
        end
    end

    always_comb begin
        pos = '0;
        for (int i = 0; i < jse_pkg::MAX_OUT; i++) begin
            pos = jse_pkg::CNT_W'(i) - {3'd0, i_item.string_start};
            if (i == 0 && i_item.string_start) begin
                o_bytes[i] = jse_pkg::CH_QUOTE;
            end else if (pos < {1'b0, body_n}) begin
                o_bytes[i] = body[pos[jse_pkg::BODY_W-1:0]];
            end else begin
                o_bytes[i] = jse_pkg::CH_QUOTE;
            end
        end
    end

    assign o_count = {3'd0, i_item.string_start} + {1'b0, body_n}
                   + {3'd0, i_item.string_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

endmodule

/* src/jse_out_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper output buffer
// Holds the bytes of one item and shifts them out one per transaction.
// ----------------------------------------------------------------------------
module jse_out_buffer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  jse_pkg::t_byte              i_bytes [jse_pkg::MAX_OUT],
    input  logic [jse_pkg::CNT_W-1:0]   i_count,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic                        o_last,
    output jse_pkg::t_byte              o_byte,
    output logic                        o_can_load
);

    jse_pkg::t_byte            r_buf [jse_pkg::MAX_OUT];
    logic [jse_pkg::CNT_W-1:0] r_left;
    logic                      take;

    assign o_valid    = (r_left != '0);
    assign o_last     = (r_left == jse_pkg::CNT_W'(1));
    assign o_byte     = r_buf[0];
    assign take       = o_valid && i_ready;
    assign o_can_load = !o_valid || (o_last && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_count;
        end else if (take) begin
            r_left <= r_left - jse_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_bytes;
        end else if (take) begin
            for (int i = 0; i < jse_pkg::MAX_OUT - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

endmodule

/* src/json_string_escaper_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper
// Turns the raw bytes of a string into quoted, escaped JSON text.
// ----------------------------------------------------------------------------
// The input channel carries one raw string byte per transaction in tdata,
// with tuser bit 0 saying the byte is present and tuser bit 1 marking the
// first item of a string; tlast marks the final item of a string. The output
// channel carries one byte of JSON text per transaction, with tlast on the
// last byte produced by an input item.
// An accepted item is encoded in the same cycle and its bytes appear on the
// output from the next cycle. A plain byte gives one output byte and items
// may be accepted in every cycle while the receiver takes every byte. An item
// that expands to N output bytes (up to eight, for quotes and six-byte
// escapes) holds the output buffer until all N have left; the next item is
// taken in the cycle in which the last of those bytes leaves. Items that
// produce nothing are taken whenever the buffer is free.
// When the receiver stalls, the current byte is held and input is refused
// until the final byte of the buffered item leaves. Reset empties the output
// buffer and clears the UTF-8 sequence and termination state.
// ----------------------------------------------------------------------------
module json_string_escaper_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic [1:0] s_axis_tuser,   // [0] has_byte, [1] string_start
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    jse_pkg::t_item            item;
    jse_pkg::t_byte            enc_bytes [jse_pkg::MAX_OUT];
    logic [jse_pkg::CNT_W-1:0] enc_count;
    logic                      accept;
    logic                      can_load;

    assign item.has_byte     = s_axis_tuser[0];
    assign item.byte_in      = s_axis_tdata;
    assign item.string_start = s_axis_tuser[1];
    assign item.string_end   = s_axis_tlast;

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    jse_encoder u_encoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_bytes  (enc_bytes),
        .o_count  (enc_count)
    );

    jse_out_buffer u_out_buffer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_bytes    (enc_bytes),
        .i_count    (enc_count),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_last     (m_axis_tlast),
        .o_byte     (m_axis_tdata),
        .o_can_load (can_load)
    );

endmodule

/* src/jse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string escaper checker
// Port-level assertions on the escaper, bound to the top level.
// ----------------------------------------------------------------------------
module jse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input refused while output is empty.");

    a_no_accept_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("Input taken while a run is still draining.");

    a_open_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[1])
        |=> (m_axis_tvalid && m_axis_tdata == 8'h22))
        else $error("String start did not open with a quote.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("Stalled output transaction changed.");

endmodule

bind json_string_escaper_unit jse_checker u_jse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the JSON string escaper
// Feeds directed and random strings into the escaper, predicts the quoted and
// escaped JSON text for every accepted transaction, and checks each output
// byte and its tlast in order, with random idling on both sides and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        jse_pkg::t_item item;
        int unsigned    gap;
    } t_offer;

    typedef struct {
        jse_pkg::t_byte text;
        logic           last;
    } t_json_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] byte_in
    logic [1:0] s_axis_tuser = 2'b00;   // [0] has_byte, [1] string_start
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;

    t_offer      pending_offers[$];
    t_json_char  json_text_q[$];
    int unsigned gap_cap = 6;
    int unsigned items_offered = 0;
    int unsigned strings_offered = 0;
    int unsigned items_taken = 0;
    int unsigned bytes_checked = 0;
    int unsigned input_stalls = 0;
    int unsigned errors = 0;

    logic        in_fired = 1'b0;
    logic        out_fired = 1'b0;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    logic        rx_steady = 1'b0;
    int unsigned hold_left = 0;
    int unsigned rx_seen = 0;
    logic        hold_used = 1'b0;

    logic [1:0]  seq_left = 2'd0;
    logic        string_ended = 1'b0;
    logic        seq_broken = 1'b0;

    json_string_escaper_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Works out the JSON text that one transaction produces and queues it.
    task automatic escape_item(input jse_pkg::t_item it);
        jse_pkg::t_byte txt[$];
        jse_pkg::t_byte b;
        jse_pkg::t_byte esc;
        b = it.byte_in;
        if (it.string_start) begin
            seq_left = 2'd0;
            string_ended = 1'b0;
            seq_broken = 1'b0;
            txt.push_back(jse_pkg::CH_QUOTE);
        end
        if (it.has_byte && !string_ended) begin
            if (seq_left != 2'd0) begin
                if (b == 8'h00) begin
                    seq_broken = 1'b1;
                end
                if (!seq_broken) begin
                    txt.push_back(b);
                end
                seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0) begin
                    seq_broken = 1'b0;
                end
            end else if (b == 8'h00) begin
                string_ended = 1'b1;
            end else if (b < 8'h80) begin
                case (b)
                    8'h08:                 esc = "b";
                    8'h09:                 esc = "t";
                    8'h0A:                 esc = "n";
                    8'h0C:                 esc = "f";
                    8'h0D:                 esc = "r";
                    jse_pkg::CH_QUOTE:     esc = jse_pkg::CH_QUOTE;
                    jse_pkg::CH_BACKSLASH: esc = jse_pkg::CH_BACKSLASH;
                    default:               esc = 8'h00;
                endcase
                if (esc != 8'h00) begin
                    txt.push_back(jse_pkg::CH_BACKSLASH);
                    txt.push_back(esc);
                end else if (b < jse_pkg::CH_SPACE || b == jse_pkg::CH_DEL) begin
                    txt.push_back(jse_pkg::CH_BACKSLASH);
                    txt.push_back("u");
                    txt.push_back("0");
                    txt.push_back("0");
                    txt.push_back((b[7:4] < 4'd10) ? jse_pkg::t_byte'("0" + b[7:4])
                                                   : jse_pkg::t_byte'("A" + b[7:4] - 10));
                    txt.push_back((b[3:0] < 4'd10) ? jse_pkg::t_byte'("0" + b[3:0])
                                                   : jse_pkg::t_byte'("A" + b[3:0] - 10));
                end else begin
                    txt.push_back(b);
                end
            end else if (b[7:5] == 3'b110) begin
                txt.push_back(b);
                seq_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                txt.push_back(b);
                seq_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                txt.push_back(b);
                seq_left = 2'd3;
            end
        end
        if (it.string_end) begin
            txt.push_back(jse_pkg::CH_QUOTE);
            seq_left = 2'd0;
            string_ended = 1'b0;
            seq_broken = 1'b0;
        end
        foreach (txt[k]) begin
            json_text_q.push_back('{text: txt[k], last: (k == txt.size() - 1)});
        end
    endtask

    task automatic offer(input logic has, input jse_pkg::t_byte b, input logic st,
                         input logic en);
        t_offer o;
        o.item.has_byte = has;
        o.item.byte_in = b;
        o.item.string_start = st;
        o.item.string_end = en;
        o.gap = $urandom_range(0, gap_cap);
        pending_offers.push_back(o);
        items_offered++;
    endtask

    // Sender: waits the drawn gap before each item, then holds it until taken.
    always @(negedge i_clk) begin
        t_offer o;
        if (i_rst_n && (!s_axis_tvalid || in_fired)) begin
            if (pending_offers.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else if (tx_wait < pending_offers[0].gap) begin
                tx_wait++;
                s_axis_tvalid <= 1'b0;
                s_axis_tdata <= jse_pkg::t_byte'($urandom);
            end else begin
                o = pending_offers.pop_front();
                tx_wait = 0;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= o.item.byte_in;
                s_axis_tuser <= {o.item.string_start, o.item.has_byte};
                s_axis_tlast <= o.item.string_end;
            end
        end
    end

    // Receiver: random stalls after each byte, with calm stretches between.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fired) begin
                if ($urandom_range(0, 39) == 0) begin
                    rx_steady = !rx_steady;
                end
                rx_wait = rx_steady ? 0 : $urandom_range(0, 6);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // One long receiver hold-off, so that the escaper fills and refuses input.
    always @(posedge i_clk) begin
        if (out_fired) begin
            rx_seen <= rx_seen + 1;
        end
        if (!hold_used && rx_seen >= 150) begin
            hold_used <= 1'b1;
            hold_left <= 80;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_json_char want;
        jse_pkg::t_item got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                bytes_checked++;
                if (json_text_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected byte %02h", m_axis_tdata));
                end else begin
                    want = json_text_q.pop_front();
                    if (m_axis_tdata !== want.text) begin
                        flag_mismatch($sformatf("byte %02h, expected %02h",
                                                m_axis_tdata, want.text));
                    end
                    if (m_axis_tlast !== want.last) begin
                        flag_mismatch($sformatf("tlast %b on byte %02h, expected %b",
                                                m_axis_tlast, m_axis_tdata, want.last));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                got.has_byte = s_axis_tuser[0];
                got.byte_in = s_axis_tdata;
                got.string_start = s_axis_tuser[1];
                got.string_end = s_axis_tlast;
                escape_item(got);
                items_taken++;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                input_stalls++;
            end
            in_fired <= s_axis_tvalid && s_axis_tready;
            out_fired <= m_axis_tvalid && m_axis_tready;
        end
    end

    initial begin
        jse_pkg::t_byte raw[$];
        jse_pkg::t_byte esc_set[7];
        int unsigned len;
        int unsigned pick;
        int unsigned nfol;
        jse_pkg::t_byte lead;
        logic sep_open;
        logic sep_close;
        esc_set = '{8'h22, 8'h5C, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D};

        // Directed: empty string, an item with nothing to do, every escape,
        // control extremes, stray high bytes and UTF-8 sequences of each length.
        offer(1'b0, 8'h41, 1'b1, 1'b1);
        offer(1'b0, 8'hA5, 1'b0, 1'b0);
        offer(1'b1, 8'h22, 1'b1, 1'b0);
        offer(1'b1, 8'h5C, 1'b0, 1'b0);
        offer(1'b1, 8'h08, 1'b0, 1'b0);
        offer(1'b1, 8'h09, 1'b0, 1'b0);
        offer(1'b1, 8'h0A, 1'b0, 1'b0);
        offer(1'b1, 8'h0C, 1'b0, 1'b0);
        offer(1'b1, 8'h0D, 1'b0, 1'b0);
        offer(1'b1, 8'h01, 1'b0, 1'b0);
        offer(1'b1, 8'h1F, 1'b0, 1'b0);
        offer(1'b1, 8'h7F, 1'b0, 1'b0);
        offer(1'b1, 8'h20, 1'b0, 1'b0);
        offer(1'b1, 8'h80, 1'b0, 1'b0);
        offer(1'b1, 8'hFF, 1'b0, 1'b0);
        offer(1'b1, 8'hC3, 1'b0, 1'b0);
        offer(1'b1, 8'hA9, 1'b0, 1'b0);
        // A zero inside a sequence drops the rest of it.
        offer(1'b1, 8'hE2, 1'b0, 1'b0);
        offer(1'b1, 8'h00, 1'b0, 1'b0);
        offer(1'b1, 8'hAC, 1'b0, 1'b0);
        offer(1'b1, 8'hF0, 1'b0, 1'b0);
        offer(1'b1, 8'h9F, 1'b0, 1'b0);
        offer(1'b1, 8'h98, 1'b0, 1'b0);
        offer(1'b1, 8'h80, 1'b0, 1'b1);
        // Truncated sequence, the longest expansion, and bytes outside a string.
        offer(1'b1, 8'hF0, 1'b1, 1'b0);
        offer(1'b1, 8'h9F, 1'b0, 1'b1);
        offer(1'b1, 8'h01, 1'b1, 1'b1);
        offer(1'b1, 8'h0A, 1'b0, 1'b0);
        // A new start abandons an unfinished sequence; a leading zero ends a string.
        offer(1'b1, 8'hE2, 1'b1, 1'b0);
        offer(1'b1, 8'h41, 1'b1, 1'b0);
        offer(1'b1, 8'h00, 1'b0, 1'b0);
        offer(1'b1, 8'h42, 1'b0, 1'b0);
        offer(1'b1, 8'h7E, 1'b0, 1'b1);
        strings_offered = 7;

        while (items_offered < 380) begin
            gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 6;
            if ($urandom_range(0, 9) == 0) begin
                offer(1'($urandom_range(0, 1)), jse_pkg::t_byte'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                raw.delete();
                len = $urandom_range(0, 10);
                while (raw.size() < len) begin
                    pick = $urandom_range(0, 19);
                    if (pick < 8) begin
                        raw.push_back(jse_pkg::t_byte'($urandom_range(8'h20, 8'h7E)));
                    end else if (pick < 10) begin
                        raw.push_back(esc_set[$urandom_range(0, 6)]);
                    end else if (pick < 12) begin
                        raw.push_back((pick == 10) ? jse_pkg::CH_DEL
                                      : jse_pkg::t_byte'($urandom_range(1, 8'h1F)));
                    end else if (pick < 16) begin
                        nfol = $urandom_range(1, 3);
                        lead = jse_pkg::t_byte'($urandom);
                        if (nfol == 1) begin
                            lead = {3'b110, lead[4:0]};
                        end else if (nfol == 2) begin
                            lead = {4'b1110, lead[3:0]};
                        end else begin
                            lead = {5'b11110, lead[2:0]};
                        end
                        raw.push_back(lead);
                        repeat (nfol) begin
                            raw.push_back(($urandom_range(0, 11) == 0) ? 8'h00
                                          : jse_pkg::t_byte'({2'b10, 6'($urandom)}));
                        end
                    end else if (pick < 19) begin
                        raw.push_back(jse_pkg::t_byte'($urandom));
                    end else begin
                        raw.push_back(8'h00);
                    end
                end
                strings_offered++;
                if (raw.size() == 0) begin
                    offer(1'b0, jse_pkg::t_byte'($urandom), 1'b1, 1'b1);
                end else begin
                    sep_open = ($urandom_range(0, 4) == 0);
                    sep_close = ($urandom_range(0, 4) == 0);
                    if (sep_open) begin
                        offer(1'b0, jse_pkg::t_byte'($urandom), 1'b1, 1'b0);
                    end
                    foreach (raw[i]) begin
                        offer(1'b1, raw[i], !sep_open && i == 0,
                              !sep_close && i == raw.size() - 1);
                    end
                    if (sep_close) begin
                        offer(1'b0, jse_pkg::t_byte'($urandom), 1'b0, 1'b1);
                    end
                end
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_offers.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (json_text_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);

        $display("Run covered %0d transactions in %0d strings and checked %0d output bytes.",
                 items_taken, strings_offered, bytes_checked);
        $display("Input was refused for %0d cycles while output was pending or held.",
                 input_stalls);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Run stopped: no progress before the time limit.");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
src/jse_pkg.sv
src/jse_encoder.sv
src/jse_out_buffer.sv
src/json_string_escaper_unit.sv
src/jse_checker.sv
sim/tb.sv
